// ===== rtl/core/ssr_pkg.sv =====
// Shared types and constants for the stream substring replace core.
// Used by the front, queue, back and top modules; no dependencies.
package ssr_pkg;

	localparam int BYTES_MAX = 8;
	localparam int CNT_W     = 4;
	localparam int IDX_W     = 3;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;

	localparam logic [1:0] CFG_PATTERN_LEN   = 2'd0;
	localparam logic [1:0] CFG_PATTERN_BYTES = 2'd1;
	localparam logic [1:0] CFG_REPLACE_LEN   = 2'd2;
	localparam logic [1:0] CFG_REPLACE_BYTES = 2'd3;

	// one queued command: bytes to send, first in lowest bits
	typedef struct packed {
		logic [8*BYTES_MAX-1:0] bytes;
		logic [CNT_W-1:0]       count;
		logic                   last;
	} cmd_t;

endpackage

// ===== rtl/core/ssr_front.sv =====
// Front end: configuration registers, sliding window and pattern compare.
// Turns each accepted item into at most one output command. Depends on ssr_pkg.
module ssr_front #(
	parameter int PATTERN_MAX = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               s_tlast,
	output logic               push,
	output ssr_pkg::cmd_t      push_cmd,
	input  logic               full
);
	import ssr_pkg::*;

	localparam int FW = $clog2(PATTERN_MAX + 1);
	localparam logic [4:0] PMAX = 5'(PATTERN_MAX);

	logic [3:0]       plen_q;
	logic [3:0]       rlen_q;
	logic [63:0]      pbytes_q;
	logic [63:0]      rbytes_q;
	logic [FW-1:0]    fill_q;
	logic [FW-1:0]    fill_d;
	logic [FW-1:0]    fill_inc;
	logic [FW-1:0]    plen_eff;
	logic [CNT_W-1:0] rlen_eff;
	logic [7:0]       win_q [PATTERN_MAX];
	logic [7:0]       win_w [PATTERN_MAX];
	logic [7:0]       win_d [PATTERN_MAX];
	logic [63:0]      win_pack;
	logic             take;
	logic             win_full;
	logic             match;
	logic             shift;

	assign cfg_ready = 1'b1;
	assign s_tready  = !full;
	assign take      = s_tvalid & s_tready;

	always_comb begin
		if (plen_q == 4'd0) begin
			plen_eff = FW'(1);
		end else if ({1'b0, plen_q} > PMAX) begin
			plen_eff = FW'(PATTERN_MAX);
		end else begin
			plen_eff = FW'(plen_q);
		end
		rlen_eff = (rlen_q > CNT_W'(BYTES_MAX)) ? CNT_W'(BYTES_MAX) : rlen_q;
	end

	// window with the new byte written at the fill position
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			win_w[i] = (FW'(i) == fill_q) ? s_tdata : win_q[i];
		end
		win_pack = '0;
		match    = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			win_pack[8*i +: 8] = win_w[i];
			if (FW'(i) < plen_eff && win_w[i] != pbytes_q[8*i +: 8]) begin
				match = 1'b0;
			end
		end
		fill_inc = fill_q + FW'(1);
		win_full = (fill_inc == plen_eff);
	end

	always_comb begin
		push_cmd       = '0;
		push_cmd.last  = s_tlast;
		shift          = 1'b0;
		fill_d         = fill_inc;
		push           = 1'b0;
		if (win_full && match) begin
			push_cmd.bytes = rbytes_q;
			push_cmd.count = rlen_eff;
			fill_d         = '0;
		end else if (win_full) begin
			if (s_tlast) begin
				push_cmd.bytes = win_pack;
				push_cmd.count = CNT_W'(plen_eff);
			end else begin
				push_cmd.bytes[7:0] = win_w[0];
				push_cmd.count      = CNT_W'(1);
			end
			shift  = 1'b1;
			fill_d = plen_eff - FW'(1);
		end else if (s_tlast) begin
			push_cmd.bytes = win_pack;
			push_cmd.count = CNT_W'(fill_inc);
		end
		if (s_tlast) begin
			fill_d = '0;
		end
		if (take && (push_cmd.count != '0 || s_tlast)) begin
			push = 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < PATTERN_MAX - 1; i++) begin
			win_d[i] = shift ? win_w[i+1] : win_w[i];
		end
		win_d[PATTERN_MAX-1] = win_w[PATTERN_MAX-1];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= win_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= 4'd1;
			pbytes_q <= '0;
			rlen_q   <= '0;
			rbytes_q <= '0;
			fill_q   <= '0;
		end else begin
			if (take) begin
				fill_q <= fill_d;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PATTERN_LEN: begin
						plen_q <= cfg_data[3:0];
						fill_q <= '0;
					end
					CFG_PATTERN_BYTES: pbytes_q <= cfg_data;
					CFG_REPLACE_LEN:   rlen_q   <= cfg_data[3:0];
					CFG_REPLACE_BYTES: rbytes_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/ssr_queue.sv =====
// Short command queue between front and back ends.
// Register storage, head presented directly. Depends on ssr_pkg.
module ssr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssr_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output ssr_pkg::cmd_t head
);
	import ssr_pkg::*;

	cmd_t              q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/ssr_back.sv =====
// Back end: walks the bytes of the queue head onto the output stream.
// Depends on ssr_pkg.
module ssr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  ssr_pkg::cmd_t head,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,  // out_byte
	output logic [0:0]    m_tuser,  // [0] out_valid
	output logic          m_tlast
);
	import ssr_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             empty_cmd;
	logic             final_byte;
	logic             take;

	assign empty_cmd  = (head.count == '0);
	assign final_byte = empty_cmd || (CNT_W'(idx_q) + CNT_W'(1) == head.count);
	assign m_tvalid   = head_valid;
	assign m_tdata    = empty_cmd ? 8'd0 : head.bytes[{idx_q, 3'b000} +: 8];
	assign m_tuser[0] = !empty_cmd;
	assign m_tlast    = head.last & final_byte;
	assign take       = m_tvalid & m_tready;
	assign pop        = take & final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= final_byte ? '0 : idx_q + IDX_W'(1);
		end
	end

endmodule

// ===== rtl/core/stream_substring_replace_core.sv =====
// Stream find-and-replace-all core. Each item's command is registered in the queue
// when the item is accepted and is offered once it reaches the queue head.
// Throughput: one item per cycle while the queue is not full; the back end sends
// one byte of the head a cycle while m_tready is high; one-byte items keep pace.
// Reset (arst_n low) empties the queue and window and restores register defaults.
module stream_substring_replace_core #(
	parameter int PATTERN_MAX = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic [0:0]  m_tuser,   // [0] out_valid
	output logic        m_tlast
);
	import ssr_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic head_valid;
	cmd_t head;

	ssr_front #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full)
	);

	ssr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	ssr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for stream_substring_replace_core: directed rows, then random
// texts with bursty input, output stalls and one long hold-off. Needs ssr_pkg and the core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ssr_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;
	localparam int RAND_ITEMS    = 434;

	typedef struct packed {
		logic [7:0] ch;
		logic       ok;
		logic       l;
	} res_t;

	typedef struct packed {
		bit          is_reg;
		logic [1:0]  idx;
		logic [63:0] val;
		logic [7:0]  ch;
		logic        l;
		bit          fixed;
		res_t        want;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // in_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // out_byte
	logic [0:0]  m_tuser;   // [0] out_valid
	logic        m_tlast;

	stream_substring_replace_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// shadow of the block
	logic [3:0]  reg_plen = 4'd1;
	logic [63:0] reg_pat  = '0;
	logic [3:0]  reg_rlen = 4'd0;
	logic [63:0] reg_rep  = '0;
	logic [7:0]  win [8];
	int unsigned fill = 0;

	res_t      step_out[$];
	res_t      pending_out[$];
	step_row_t dir_rows[$];
	res_t      head;
	int        errors = 0;
	int        burst_left = 0;
	bit        gaps_on = 1'b1;
	int        hold_ask = 0;
	int        stall_count = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned pat_span();
		if (reg_plen == 4'd0)
			return 1;
		return (reg_plen > 4'd8) ? 8 : reg_plen;
	endfunction

	function automatic void emit(input logic [7:0] ch, input logic ok);
		res_t r;
		r.ch = ch;
		r.ok = ok;
		r.l = 1'b0;
		if (step_out.size() < 8)
			step_out.push_back(r);
	endfunction

	function automatic void drop_oldest();
		emit(win[0], 1'b1);
		for (int i = 0; i < 7; i++)
			win[i] = win[i + 1];
		fill--;
	endfunction

	function automatic void apply_reg(input logic [1:0] idx, input logic [63:0] val);
		case (idx)
			CFG_PATTERN_LEN: begin
				reg_plen = val[3:0];
				fill = 0;
			end
			CFG_PATTERN_BYTES: reg_pat = val;
			CFG_REPLACE_LEN: reg_rlen = val[3:0];
			default: reg_rep = val;
		endcase
	endfunction

	// results one text character causes, left in step_out
	function automatic void rewrite_byte(input logic [7:0] ch, input logic l);
		int unsigned plen;
		int unsigned rlen;
		bit hit;
		res_t r;
		plen = pat_span();
		rlen = (reg_rlen > 4'd8) ? 8 : reg_rlen;
		step_out.delete();
		while (fill >= plen && fill > 0 && step_out.size() < 8)
			drop_oldest();
		if (fill < 8) begin
			win[fill] = ch;
			fill++;
		end
		if (fill == plen) begin
			hit = 1'b1;
			for (int i = 0; i < plen; i++)
				if (win[i] != reg_pat[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				for (int i = 0; i < rlen; i++)
					emit(reg_rep[8*i +: 8], 1'b1);
				fill = 0;
			end else if (step_out.size() < 8) begin
				drop_oldest();
			end
		end
		if (l) begin
			for (int i = 0; i < fill; i++)
				emit(win[i], 1'b1);
			fill = 0;
			if (step_out.size() == 0)
				emit(8'h00, 1'b0);
			r = step_out.pop_back();
			r.l = 1'b1;
			step_out.push_back(r);
		end
	endfunction

	task automatic send_byte(input logic [7:0] ch, input logic l, input bit fixed,
			input res_t want);
		cfg_valid <= 1'b0;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		rewrite_byte(ch, l);
		if (fixed)
			pending_out.push_back(want);
		else
			foreach (step_out[i])
				pending_out.push_back(step_out[i]);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void add_reg(input logic [1:0] idx, input logic [63:0] val);
		step_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.idx = idx;
		row.val = val;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_char(input logic [7:0] ch, input logic l, input bit fixed,
			input res_t want);
		step_row_t row;
		row = '0;
		row.ch = ch;
		row.l = l;
		row.fixed = fixed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	// receiver: own stall pattern, plus a long hold-off on request
	initial begin
		int seg_left;
		int mode;
		int hold_left;
		int hold_seen;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		hold_seen = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 2);
					seg_left = $urandom_range(5, 60);
				end
				seg_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_out.size() == 0) begin
				$error("unexpected item: out_byte %02h out_valid %0d out_last %0d",
					m_tdata, m_tuser[0], m_tlast);
				errors++;
			end else begin
				head = pending_out.pop_front();
				if (m_tdata !== head.ch) begin
					$error("out_byte: expected %02h, got %02h", head.ch, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== head.ok) begin
					$error("out_valid: expected %0d, got %0d", head.ok, m_tuser[0]);
					errors++;
				end
				if (m_tlast !== head.l) begin
					$error("out_last: expected %0d, got %0d", head.l, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	initial begin
		step_row_t row;
		bit prev_reg;
		logic [63:0] v;
		logic [7:0] text_q[$];
		int rand_items;
		int phase;
		int n_texts;
		int len;
		int span;
		int r;
		int k;
		bit alpha;
		bit open_end;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < 8; i++)
			win[i] = '0;

		// after reset: pattern is one zero byte, empty replacement
		add_char(8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1});
		add_char(8'h41, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b0});
		// zero pattern length acts as one
		add_reg(CFG_PATTERN_LEN, 64'd0);
		add_char(8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1});
		// "abc", replacement length saturates at 8
		add_reg(CFG_PATTERN_LEN, 64'd3);
		add_reg(CFG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
		add_reg(CFG_REPLACE_LEN, 64'd15);
		add_reg(CFG_REPLACE_BYTES, 64'hFF80_7F01_00AA_5533);
		add_char(8'h61, 1'b0, 1'b0, '0);
		add_char(8'h62, 1'b0, 1'b0, '0);
		add_char(8'h63, 1'b0, 1'b0, '0);
		add_char(8'h78, 1'b0, 1'b0, '0);
		add_char(8'h61, 1'b0, 1'b0, '0);
		add_char(8'h62, 1'b1, 1'b0, '0);
		// left in the window, dropped by the length write
		add_char(8'h61, 1'b0, 1'b0, '0);
		// length above the maximum saturates; matches deleted
		add_reg(CFG_PATTERN_LEN, 64'd15);
		add_reg(CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
		add_reg(CFG_REPLACE_LEN, 64'd0);
		for (int i = 0; i < 7; i++)
			add_char(8'hFF, 1'b0, 1'b0, '0);
		add_char(8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1});
		for (int i = 0; i < 7; i++)
			add_char(8'hFF, 1'b0, 1'b0, '0);
		add_char(8'h00, 1'b1, 1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_reg = 1'b0;
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_reg) begin
				if (!prev_reg)
					settle();
				write_reg(row.idx, row.val);
			end else begin
				send_byte(row.ch, row.l, row.fixed, row.want);
			end
			prev_reg = row.is_reg;
		end

		rand_items = 0;
		phase = 0;
		while (rand_items < RAND_ITEMS) begin
			settle();
			phase++;
			if (phase == 1 || $urandom_range(0, 1) == 1) begin
				v = {$urandom, $urandom};
				r = $urandom_range(0, 9);
				v[3:0] = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : 4'($urandom_range(1, 8));
				write_reg(CFG_PATTERN_LEN, v);
			end
			if (phase == 1 || $urandom_range(0, 1) == 1) begin
				alpha = ($urandom_range(0, 2) != 0);
				for (k = 0; k < 8; k++)
					v[8*k +: 8] = alpha ? 8'h61 + 8'($urandom_range(0, 1))
						: 8'($urandom_range(0, 255));
				write_reg(CFG_PATTERN_BYTES, v);
			end
			if (phase == 1 || $urandom_range(0, 1) == 1) begin
				v = {$urandom, $urandom};
				r = $urandom_range(0, 11);
				v[3:0] = (r > 8) ? 4'($urandom_range(9, 15)) : 4'(r);
				write_reg(CFG_REPLACE_LEN, v);
			end
			if (phase == 1 || $urandom_range(0, 1) == 1)
				write_reg(CFG_REPLACE_BYTES, {$urandom, $urandom});

			if (phase == 3) begin
				hold_ask <= hold_ask + 1;
				gaps_on = 1'b0;
			end else begin
				gaps_on = ($urandom_range(0, 3) != 0);
			end

			n_texts = $urandom_range(2, 5);
			for (int t = 0; t < n_texts; t++) begin
				text_q.delete();
				len = $urandom_range(1, 24);
				span = pat_span();
				while (text_q.size() < len) begin
					r = $urandom_range(0, 9);
					if (r < 4) begin
						for (k = 0; k < span; k++)
							text_q.push_back(reg_pat[8*k +: 8]);
					end else if (r < 8) begin
						k = $urandom_range(0, span - 1);
						text_q.push_back(reg_pat[8*k +: 8]);
					end else begin
						text_q.push_back(8'($urandom_range(0, 255)));
					end
				end
				open_end = (t == n_texts - 1) && ($urandom_range(0, 3) == 0);
				foreach (text_q[i])
					send_byte(text_q[i], (i == text_q.size() - 1) && !open_end, 1'b0, '0);
				rand_items += text_q.size();
			end
		end

		settle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ssr_pkg.sv
rtl/core/ssr_front.sv
rtl/core/ssr_queue.sv
rtl/core/ssr_back.sv
rtl/core/stream_substring_replace_core.sv
bench/tb_top.sv
